// ===== src/kab_pkg.sv =====
package kab_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam int IO_W     = 32;
	localparam int DT_W     = 24;
	localparam int NOISE_W  = 31;
	localparam int COV_W    = 32;
	localparam int GAIN_W   = 32;
	localparam int INNER_W  = COV_W + 2;
	localparam int SUM_W    = COV_W + 2;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int CHUNK_W  = 24;
	localparam int SHIFT_LO = 24;
	localparam int SHIFT_HI = 30;

	localparam int DIV_W         = 32;
	localparam int DIV_STEP_BITS = 2;
	localparam int DIV_CYC       = DIV_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_CYC);

	localparam logic [DT_W-1:0]    DT_RST    = 24'd167772;
	localparam logic [NOISE_W-1:0] QA_RST    = 31'd1073742;
	localparam logic [NOISE_W-1:0] QB_RST    = 31'd3221225;
	localparam logic [NOISE_W-1:0] R_RST     = 31'd32212255;
	localparam logic [COV_W-1:0]   COV_ONE   = 32'h4000_0000;
	localparam logic [COV_W-1:0]   COV_MAX   = 32'h7FFF_FFFF;
	localparam logic [COV_W-1:0]   COV_MIN   = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_PERIOD = 8'd0,
		REG_ANGLE_NOISE   = 8'd1,
		REG_BIAS_NOISE    = 8'd2,
		REG_MEAS_NOISE    = 8'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ANG_PRED,
		S_DP,
		S_INNER,
		S_P00_PRED,
		S_COV_PRED,
		S_DIV_INIT,
		S_DIV_RUN,
		S_DIV_END,
		S_INNOV,
		S_ANG_COR,
		S_BIAS_COR,
		S_COV_P10,
		S_COV_P11,
		S_COV_P00,
		S_COV_P01,
		S_RESULT
	} step_t;

	typedef enum logic [1:0] {
		PH_LO,
		PH_HI,
		PH_ACC,
		PH_WB
	} mul_ph_t;

endpackage

// ===== src/kab_if.sv =====
interface kab_meas_if;
	logic                              valid;
	logic                              ready;
	logic signed [kab_pkg::IO_W-1:0]   measured_angle;
	logic signed [kab_pkg::IO_W-1:0]   measured_rate;

	modport source (output valid, output measured_angle, output measured_rate, input ready);
	modport sink   (input valid, input measured_angle, input measured_rate, output ready);
endinterface

interface kab_est_if;
	logic                              valid;
	logic                              ready;
	logic signed [kab_pkg::IO_W-1:0]   filtered_angle;
	logic signed [kab_pkg::IO_W-1:0]   bias_estimate;
	logic signed [kab_pkg::IO_W-1:0]   corrected_rate;

	modport source (output valid, output filtered_angle, output bias_estimate,
		output corrected_rate, input ready);
	modport sink   (input valid, input filtered_angle, input bias_estimate,
		input corrected_rate, output ready);
endinterface

interface kab_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [kab_pkg::CFG_IDX_W-1:0]        index;
	logic [kab_pkg::CFG_DATA_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/kalman_angle_bias_filter_unit.sv =====
// Two-state angle / gyro-bias Kalman filter, fixed point.
//
// meas: one request per sample, measured angle and gyro rate (signed Q16.16).
// est:  one request per sample, filtered angle, bias estimate and corrected
//       rate (signed Q16.16, saturated).
// cfg:  register writes (sample period, process noises, measurement noise);
//       always ready, to be used only while the filter is idle.
//
// Timing: meas.ready is high only while idle. The time per sample is set by one
// shared 25x32 multiplier (nine products) and one divider that retires two
// quotient bits per cycle (two gains). A new request is taken only after the
// result of the last one is loaded into the output register.
//
// The result sits in an output register: a stalled receiver does not block
// the next request. If that register is still full when the next result is
// done, the filter holds until est.ready frees it.
//
// Reset: angle, bias and rate clear to zero, the covariance returns to the
// identity and the registers return to their defaults.
module kalman_angle_bias_filter_unit #(
	parameter int DATA_WIDTH = kab_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kab_meas_if.sink   meas,
	kab_est_if.source  est,
	kab_cfg_if.sink    cfg
);

	localparam int DW   = DATA_WIDTH;
	localparam int AW   = ((DW > 33) ? DW : 33) + 1;
	localparam int LW   = kab_pkg::CHUNK_W;
	localparam int CW   = ((AW - LW) > (LW + 1)) ? (AW - LW) : (LW + 1);
	localparam int BW   = kab_pkg::GAIN_W;
	localparam int PW   = CW + BW;
	localparam int ACCW = AW + BW + 1;
	localparam int QW   = kab_pkg::DIV_W;
	localparam logic [ACCW-1:0] RND_LO = ACCW'({kab_pkg::SHIFT_LO{1'b1}});
	localparam logic [ACCW-1:0] RND_HI = ACCW'({kab_pkg::SHIFT_HI{1'b1}});

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACCW-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[ACCW-1:DW-1];
		all_zero = ~|v[ACCW-1:DW-1];
		if (all_one || all_zero) begin
			return v[DW-1:0];
		end
		return v[ACCW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	endfunction

	function automatic logic signed [kab_pkg::COV_W-1:0] sat32(
		input logic signed [ACCW-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[ACCW-1:kab_pkg::COV_W-1];
		all_zero = ~|v[ACCW-1:kab_pkg::COV_W-1];
		if (all_one || all_zero) begin
			return v[kab_pkg::COV_W-1:0];
		end
		return v[ACCW-1] ? kab_pkg::COV_MIN : kab_pkg::COV_MAX;
	endfunction

	kab_pkg::step_t   state_q, state_d;
	kab_pkg::mul_ph_t ph_q, ph_d;

	logic [kab_pkg::DT_W-1:0]    dt_q;
	logic [kab_pkg::NOISE_W-1:0] qa_q, qb_q, r_q;

	logic signed [DW-1:0]             angle_q, bias_q, rate_q;
	logic signed [kab_pkg::COV_W-1:0] p00_q, p01_q, p10_q, p11_q;

	logic signed [kab_pkg::IO_W-1:0]    m_angle_q;
	logic signed [kab_pkg::COV_W-1:0]   dp_q;
	logic signed [kab_pkg::INNER_W-1:0] inner_q;
	logic signed [kab_pkg::SUM_W-1:0]   s_q;
	logic signed [kab_pkg::GAIN_W-1:0]  k0_q, k1_q;
	logic signed [AW-1:0]               y_q;

	logic signed [PW-1:0]   prod_q;
	logic signed [ACCW-1:0] acc_q;

	logic [QW-1:0]                 rem_q, num_q, den_q, quo_q;
	logic [kab_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          neg_q, ovf_q, dzero_q, ksel_q;

	logic signed [kab_pkg::IO_W-1:0] out_angle_q, out_bias_q, out_rate_q;
	logic                            out_valid_q;

	logic                   mul_en, mul_sub, mul_s30;
	logic signed [AW-1:0]   mul_a, mul_add;
	logic signed [BW-1:0]   mul_b;
	logic signed [CW-1:0]   mul_chunk;
	logic signed [PW-1:0]   mult_out;
	logic signed [ACCW-1:0] prod_ext, add_sh, acc_init, mul_res;

	logic [QW-1:0]                  rem_n, num_n, quo_n;
	logic [QW-1:0]                  pabs, dabs;
	logic signed [kab_pkg::COV_W-1:0] div_p;
	logic signed [kab_pkg::GAIN_W-1:0] kval;

	logic in_take, res_load, div_last;

	assign in_take  = meas.valid && meas.ready;
	assign res_load = (state_q == kab_pkg::S_RESULT) && (!out_valid_q || est.ready);
	assign div_last = (cnt_q == kab_pkg::DIV_CNT_W'(kab_pkg::DIV_CYC - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kab_pkg::S_IDLE:     if (meas.valid) state_d = kab_pkg::S_ANG_PRED;
			kab_pkg::S_ANG_PRED: if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_DP;
			kab_pkg::S_DP:       if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_INNER;
			kab_pkg::S_INNER:    state_d = kab_pkg::S_P00_PRED;
			kab_pkg::S_P00_PRED: if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_COV_PRED;
			kab_pkg::S_COV_PRED: state_d = kab_pkg::S_DIV_INIT;
			kab_pkg::S_DIV_INIT: state_d = kab_pkg::S_DIV_RUN;
			kab_pkg::S_DIV_RUN:  if (div_last) state_d = kab_pkg::S_DIV_END;
			kab_pkg::S_DIV_END:  state_d = ksel_q ? kab_pkg::S_INNOV : kab_pkg::S_DIV_INIT;
			kab_pkg::S_INNOV:    state_d = kab_pkg::S_ANG_COR;
			kab_pkg::S_ANG_COR:  if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_BIAS_COR;
			kab_pkg::S_BIAS_COR: if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_COV_P10;
			kab_pkg::S_COV_P10:  if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_COV_P11;
			kab_pkg::S_COV_P11:  if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_COV_P00;
			kab_pkg::S_COV_P00:  if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_COV_P01;
			kab_pkg::S_COV_P01:  if (ph_q == kab_pkg::PH_WB) state_d = kab_pkg::S_RESULT;
			kab_pkg::S_RESULT:   if (!out_valid_q || est.ready) state_d = kab_pkg::S_IDLE;
			default:             state_d = kab_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		meas.ready = (state_q == kab_pkg::S_IDLE);
		cfg.ready  = 1'b1;
		mul_en     = 1'b0;
		mul_sub    = 1'b0;
		mul_s30    = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		mul_add    = '0;
		unique case (state_q)
			kab_pkg::S_ANG_PRED: begin
				mul_en  = 1'b1;
				mul_a   = AW'(rate_q);
				mul_b   = BW'(dt_q);
				mul_add = AW'(angle_q);
			end
			kab_pkg::S_DP: begin
				mul_en  = 1'b1;
				mul_a   = AW'(p11_q);
				mul_b   = BW'(dt_q);
			end
			kab_pkg::S_P00_PRED: begin
				mul_en  = 1'b1;
				mul_a   = AW'(inner_q);
				mul_b   = BW'(dt_q);
				mul_add = AW'(p00_q);
			end
			kab_pkg::S_ANG_COR: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_a   = y_q;
				mul_b   = k0_q;
				mul_add = AW'(angle_q);
			end
			kab_pkg::S_BIAS_COR: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_a   = y_q;
				mul_b   = k1_q;
				mul_add = AW'(bias_q);
			end
			kab_pkg::S_COV_P10: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_sub = 1'b1;
				mul_a   = AW'(p00_q);
				mul_b   = k1_q;
				mul_add = AW'(p10_q);
			end
			kab_pkg::S_COV_P11: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_sub = 1'b1;
				mul_a   = AW'(p01_q);
				mul_b   = k1_q;
				mul_add = AW'(p11_q);
			end
			kab_pkg::S_COV_P00: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_sub = 1'b1;
				mul_a   = AW'(p00_q);
				mul_b   = k0_q;
				mul_add = AW'(p00_q);
			end
			kab_pkg::S_COV_P01: begin
				mul_en  = 1'b1;
				mul_s30 = 1'b1;
				mul_sub = 1'b1;
				mul_a   = AW'(p01_q);
				mul_b   = k0_q;
				mul_add = AW'(p01_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ph_d = kab_pkg::PH_LO;
		if (mul_en) begin
			unique case (ph_q)
				kab_pkg::PH_LO:  ph_d = kab_pkg::PH_HI;
				kab_pkg::PH_HI:  ph_d = kab_pkg::PH_ACC;
				kab_pkg::PH_ACC: ph_d = kab_pkg::PH_WB;
				kab_pkg::PH_WB:  ph_d = kab_pkg::PH_LO;
				default:         ph_d = kab_pkg::PH_LO;
			endcase
		end
	end

	// addend + floor(a*b / 2^s) or addend - floor(a*b / 2^s), built from two partial products
	always_comb begin
		if (ph_q == kab_pkg::PH_LO) begin
			mul_chunk = CW'($signed({1'b0, mul_a[LW-1:0]}));
		end else begin
			mul_chunk = CW'($signed(mul_a[AW-1:LW]));
		end
		mult_out = mul_chunk * mul_b;
		prod_ext = ACCW'(prod_q);
		add_sh   = mul_s30 ? (ACCW'(mul_add) <<< kab_pkg::SHIFT_HI)
			: (ACCW'(mul_add) <<< kab_pkg::SHIFT_LO);
		if (mul_sub) begin
			acc_init = (add_sh | (mul_s30 ? RND_HI : RND_LO)) - prod_ext;
		end else begin
			acc_init = add_sh + prod_ext;
		end
		mul_res = mul_s30 ? (acc_q >>> kab_pkg::SHIFT_HI) : (acc_q >>> kab_pkg::SHIFT_LO);
	end

	always_comb begin
		logic [QW:0] trial;
		rem_n = rem_q;
		num_n = num_q;
		quo_n = quo_q;
		for (int j = 0; j < kab_pkg::DIV_STEP_BITS; j++) begin
			trial = {rem_n, num_n[QW-1]};
			num_n = {num_n[QW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n = QW'(trial - {1'b0, den_q});
				quo_n = {quo_n[QW-2:0], 1'b1};
			end else begin
				rem_n = trial[QW-1:0];
				quo_n = {quo_n[QW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		div_p = ksel_q ? p10_q : p00_q;
		pabs  = div_p[kab_pkg::COV_W-1] ? QW'(-div_p) : QW'(div_p);
		dabs  = s_q[kab_pkg::SUM_W-1] ? QW'(-s_q) : QW'(s_q);
		if (dzero_q) begin
			kval = '0;
		end else if (neg_q) begin
			kval = (ovf_q || (quo_q > kab_pkg::COV_MIN)) ? kab_pkg::COV_MIN : QW'(-quo_q);
		end else begin
			kval = (ovf_q || quo_q[QW-1]) ? kab_pkg::COV_MAX : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kab_pkg::S_IDLE;
			ph_q        <= kab_pkg::PH_LO;
			ksel_q      <= 1'b0;
			out_valid_q <= 1'b0;
			dt_q        <= kab_pkg::DT_RST;
			qa_q        <= kab_pkg::QA_RST;
			qb_q        <= kab_pkg::QB_RST;
			r_q         <= kab_pkg::R_RST;
			angle_q     <= '0;
			bias_q      <= '0;
			rate_q      <= '0;
			p00_q       <= kab_pkg::COV_ONE;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= kab_pkg::COV_ONE;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;

			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (est.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				unique case (cfg.index)
					kab_pkg::REG_SAMPLE_PERIOD: dt_q <= cfg.data[kab_pkg::DT_W-1:0];
					kab_pkg::REG_ANGLE_NOISE:   qa_q <= cfg.data[kab_pkg::NOISE_W-1:0];
					kab_pkg::REG_BIAS_NOISE:    qb_q <= cfg.data[kab_pkg::NOISE_W-1:0];
					kab_pkg::REG_MEAS_NOISE:    r_q  <= cfg.data[kab_pkg::NOISE_W-1:0];
					default: begin
					end
				endcase
			end

			if (in_take) begin
				rate_q <= sat_dw(ACCW'(meas.measured_rate) - ACCW'(bias_q));
			end

			if (state_q == kab_pkg::S_COV_PRED) begin
				p01_q <= sat32(ACCW'(p01_q) - ACCW'(dp_q));
				p10_q <= sat32(ACCW'(p10_q) - ACCW'(dp_q));
				p11_q <= sat32(ACCW'(p11_q) + ACCW'($signed({1'b0, qb_q})));
			end

			if (state_q == kab_pkg::S_DIV_END) begin
				ksel_q <= ~ksel_q;
			end

			if (ph_q == kab_pkg::PH_WB) begin
				unique case (state_q)
					kab_pkg::S_ANG_PRED, kab_pkg::S_ANG_COR: angle_q <= sat_dw(mul_res);
					kab_pkg::S_BIAS_COR: bias_q <= sat_dw(mul_res);
					kab_pkg::S_P00_PRED, kab_pkg::S_COV_P00: p00_q <= sat32(mul_res);
					kab_pkg::S_COV_P01: p01_q <= sat32(mul_res);
					kab_pkg::S_COV_P10: p10_q <= sat32(mul_res);
					kab_pkg::S_COV_P11: p11_q <= sat32(mul_res);
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			m_angle_q <= meas.measured_angle;
		end

		if (mul_en) begin
			unique case (ph_q)
				kab_pkg::PH_LO: prod_q <= mult_out;
				kab_pkg::PH_HI: begin
					prod_q <= mult_out;
					acc_q  <= acc_init;
				end
				kab_pkg::PH_ACC: begin
					if (mul_sub) begin
						acc_q <= acc_q - (prod_ext <<< kab_pkg::CHUNK_W);
					end else begin
						acc_q <= acc_q + (prod_ext <<< kab_pkg::CHUNK_W);
					end
				end
				default: begin
				end
			endcase
		end

		if ((state_q == kab_pkg::S_DP) && (ph_q == kab_pkg::PH_WB)) begin
			dp_q <= sat32(mul_res);
		end

		if (state_q == kab_pkg::S_INNER) begin
			inner_q <= kab_pkg::INNER_W'(dp_q) - kab_pkg::INNER_W'(p01_q)
				- kab_pkg::INNER_W'(p10_q) + kab_pkg::INNER_W'($signed({1'b0, qa_q}));
		end

		if (state_q == kab_pkg::S_COV_PRED) begin
			s_q <= kab_pkg::SUM_W'(p00_q) + kab_pkg::SUM_W'($signed({1'b0, r_q}));
		end

		unique case (state_q)
			kab_pkg::S_DIV_INIT: begin
				rem_q   <= QW'(pabs[QW-1:2]);
				num_q   <= {pabs[1:0], {(QW-2){1'b0}}};
				den_q   <= dabs;
				quo_q   <= '0;
				cnt_q   <= '0;
				neg_q   <= div_p[kab_pkg::COV_W-1] ^ s_q[kab_pkg::SUM_W-1];
				ovf_q   <= (QW'(pabs[QW-1:2]) >= dabs);
				dzero_q <= (s_q == '0);
			end
			kab_pkg::S_DIV_RUN: begin
				rem_q <= rem_n;
				num_q <= num_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q + 1'b1;
			end
			kab_pkg::S_DIV_END: begin
				if (ksel_q) begin
					k1_q <= kval;
				end else begin
					k0_q <= kval;
				end
			end
			kab_pkg::S_INNOV: begin
				y_q <= AW'(m_angle_q) - AW'(angle_q);
			end
			default: begin
			end
		endcase

		if (res_load) begin
			out_angle_q <= sat32(ACCW'(angle_q));
			out_bias_q  <= sat32(ACCW'(bias_q));
			out_rate_q  <= sat32(ACCW'(rate_q));
		end
	end

	assign est.valid          = out_valid_q;
	assign est.filtered_angle = out_angle_q;
	assign est.bias_estimate  = out_bias_q;
	assign est.corrected_rate = out_rate_q;

endmodule

// ===== src/kab_checker.sv =====
module kab_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             meas_valid,
	input logic                             meas_ready,
	input logic                             est_valid,
	input logic                             est_ready,
	input logic signed [kab_pkg::IO_W-1:0]  est_angle,
	input logic signed [kab_pkg::IO_W-1:0]  est_bias,
	input logic signed [kab_pkg::IO_W-1:0]  est_rate
);

	a_est_hold: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && !est_ready |=> est_valid && $stable(est_angle)
			&& $stable(est_bias) && $stable(est_rate))
		else $error("result changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready ##1 !meas_ready)
		else $error("filter took a request while busy");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(est_valid) |-> $past(!meas_ready))
		else $error("result appeared while idle");

endmodule

bind kalman_angle_bias_filter_unit kab_checker u_kab_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas.valid),
	.meas_ready (meas.ready),
	.est_valid  (est.valid),
	.est_ready  (est.ready),
	.est_angle  (est.filtered_angle),
	.est_bias   (est.bias_estimate),
	.est_rate   (est.corrected_rate)
);

// ===== tb/kab_filter_checker.sv =====
`timescale 1ns / 1ps

module kab_filter_checker (
	input  logic        clk,
	input  logic        arst_n,
	kab_meas_if         meas,
	kab_est_if          est,
	kab_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	import kab_pkg::*;

	localparam longint SAT_HI = (longint'(1) <<< (IO_W - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic signed [IO_W-1:0] angle;
		logic signed [IO_W-1:0] bias;
		logic signed [IO_W-1:0] rate;
	} estimate_t;

	longint      dt_q24;
	longint      qa_q30;
	longint      qb_q30;
	longint      r_q30;
	longint      angle_q16;
	longint      bias_q16;
	longint      rate_q16;
	longint      cov [4];
	estimate_t   estimate_q [$];
	estimate_t   want;
	estimate_t   got;
	int unsigned fail_cnt;

	function automatic longint clamp32(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// floor(a * b / 2^sh)
	function automatic longint scaled_product(input longint a, input longint b, input int sh);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] wide;
		wa = a;
		wb = b;
		wide = (wa * wb) >>> sh;
		return longint'(wide);
	endfunction

	function automatic estimate_t kalman_step(input longint m_angle, input longint m_rate);
		longint    p00, p01, p10, p11, dp, inner, s, k0, k1, y;
		estimate_t res;
		k0 = 0;
		k1 = 0;
		// predict
		rate_q16  = clamp32(m_rate - bias_q16);
		angle_q16 = clamp32(angle_q16 + scaled_product(rate_q16, dt_q24, SHIFT_LO));
		dp    = scaled_product(cov[3], dt_q24, SHIFT_LO);
		inner = dp - cov[1] - cov[2] + qa_q30;
		p00   = clamp32(cov[0] + scaled_product(inner, dt_q24, SHIFT_LO));
		p01   = clamp32(cov[1] - dp);
		p10   = clamp32(cov[2] - dp);
		p11   = clamp32(cov[3] + qb_q30);
		// correct; a zero innovation variance leaves both gains at zero
		s = p00 + r_q30;
		if (s != 0) begin
			k0 = clamp32((p00 <<< SHIFT_HI) / s);
			k1 = clamp32((p10 <<< SHIFT_HI) / s);
		end
		y = m_angle - angle_q16;
		angle_q16 = clamp32(angle_q16 + scaled_product(y, k0, SHIFT_HI));
		bias_q16  = clamp32(bias_q16 + scaled_product(y, k1, SHIFT_HI));
		cov[0] = clamp32(p00 - scaled_product(p00, k0, SHIFT_HI));
		cov[1] = clamp32(p01 - scaled_product(p01, k0, SHIFT_HI));
		cov[2] = clamp32(p10 - scaled_product(p00, k1, SHIFT_HI));
		cov[3] = clamp32(p11 - scaled_product(p01, k1, SHIFT_HI));
		res.angle = IO_W'(angle_q16);
		res.bias  = IO_W'(bias_q16);
		res.rate  = IO_W'(rate_q16);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q24    = longint'(DT_RST);
			qa_q30    = longint'(QA_RST);
			qb_q30    = longint'(QB_RST);
			r_q30     = longint'(R_RST);
			angle_q16 = 0;
			bias_q16  = 0;
			rate_q16  = 0;
			cov[0]    = longint'(COV_ONE);
			cov[1]    = 0;
			cov[2]    = 0;
			cov[3]    = longint'(COV_ONE);
			estimate_q.delete();
			fail_cnt  = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SAMPLE_PERIOD: dt_q24 = longint'(cfg.data[DT_W-1:0]);
					REG_ANGLE_NOISE:   qa_q30 = longint'(cfg.data[NOISE_W-1:0]);
					REG_BIAS_NOISE:    qb_q30 = longint'(cfg.data[NOISE_W-1:0]);
					REG_MEAS_NOISE:    r_q30  = longint'(cfg.data[NOISE_W-1:0]);
					default: ;
				endcase
			end
			// retire before taking a new request: a result never belongs to
			// the request taken at the same edge
			if (est.valid && est.ready) begin
				got.angle = est.filtered_angle;
				got.bias  = est.bias_estimate;
				got.rate  = est.corrected_rate;
				if (estimate_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected estimate angle %0d bias %0d rate %0d",
							$time, got.angle, got.bias, got.rate);
				end else begin
					want = estimate_q.pop_front();
					if (got.angle !== want.angle || got.bias !== want.bias ||
							got.rate !== want.rate) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: expected a/b/r %0d %0d %0d, got %0d %0d %0d",
								$time, want.angle, want.bias, want.rate,
								got.angle, got.bias, got.rate);
					end
				end
			end
			if (meas.valid && meas.ready)
				estimate_q.push_back(kalman_step(longint'(meas.measured_angle),
					longint'(meas.measured_rate)));
			mismatches  <= fail_cnt;
			outstanding <= estimate_q.size();
		end
	end

endmodule

// ===== tb/tb_kalman_angle_bias_filter_unit.sv =====
`timescale 1ns / 1ps

module tb_kalman_angle_bias_filter_unit;
	import kab_pkg::*;

	localparam int SAMPLE_LATENCY    = 77;
	localparam int RANDOM_PHASES     = 7;
	localparam int SAMPLES_PER_PHASE = 100;
	localparam int QUIET_PHASE       = 3;
	localparam int DEG               = 65536;
	localparam logic signed [IO_W-1:0] FULL_POS = 32'sh7FFF_FFFF;
	localparam logic signed [IO_W-1:0] FULL_NEG = 32'sh8000_0000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        gaps_on;
	int unsigned stall_left = 0;
	int unsigned mismatches;
	int unsigned outstanding;
	int          heading;
	int          gyro_offset;

	kab_meas_if meas_if ();
	kab_est_if  est_if ();
	kab_cfg_if  cfg_if ();

	kalman_angle_bias_filter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_if),
		.est    (est_if),
		.cfg    (cfg_if)
	);

	kab_filter_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.meas        (meas_if),
		.est         (est_if),
		.cfg         (cfg_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
	endfunction

	function automatic int spread(input int unsigned span);
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_period();
		case ($urandom_range(0, 5))
			0: return CFG_DATA_W'(DT_RST);
			1: return CFG_DATA_W'($urandom_range(1, 1 << 21));
			2: return $urandom;
			3: return CFG_DATA_W'(1);
			4: return CFG_DATA_W'({DT_W{1'b1}});
			default: return CFG_DATA_W'($urandom_range(100000, 400000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_noise(input logic [NOISE_W-1:0] typical);
		case ($urandom_range(0, 4))
			0: return CFG_DATA_W'(typical);
			1: return CFG_DATA_W'($urandom_range(0, 1 << 26));
			2: return $urandom;
			3: return CFG_DATA_W'({NOISE_W{1'b1}});
			default: return CFG_DATA_W'($urandom_range(1, 1000));
		endcase
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			est_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			est_if.ready <= 1'b0;
			stall_left   <= pick_gap();
		end else begin
			est_if.ready <= 1'b1;
		end
	end

	task automatic push_sample(input logic signed [IO_W-1:0] angle,
			input logic signed [IO_W-1:0] rate);
		int unsigned gap;
		gap = (gaps_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
		if (gap != 0) begin
			meas_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas_if.valid          <= 1'b1;
		meas_if.measured_angle <= angle;
		meas_if.measured_rate  <= rate;
		do @(posedge clk); while (!meas_if.ready);
	endtask

	// drop the request line, drain every estimate, hold until the filter is idle
	task automatic settle();
		meas_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		while (!meas_if.ready) @(posedge clk);
	endtask

	task automatic program_filter(input logic [CFG_DATA_W-1:0] dt_w,
			input logic [CFG_DATA_W-1:0] qa_w, input logic [CFG_DATA_W-1:0] qb_w,
			input logic [CFG_DATA_W-1:0] r_w, input bit stray);
		cfg_reg_t              regs [4];
		logic [CFG_DATA_W-1:0] words [4];
		regs  = '{REG_SAMPLE_PERIOD, REG_ANGLE_NOISE, REG_BIAS_NOISE, REG_MEAS_NOISE};
		words = '{dt_w, qa_w, qb_w, r_w};
		for (int i = 0; i < 4; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= regs[i];
			cfg_if.data  <= words[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		if (stray) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= CFG_IDX_W'($urandom_range(REG_MEAS_NOISE + 1, (1 << CFG_IDX_W) - 1));
			cfg_if.data  <= $urandom;
			do @(posedge clk); while (!cfg_if.ready);
		end
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		gaps_on                = 1'b0;
		meas_if.valid          = 1'b0;
		meas_if.measured_angle = '0;
		meas_if.measured_rate  = '0;
		est_if.ready           = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.index           = REG_SAMPLE_PERIOD;
		cfg_if.data            = '0;
		heading                = 0;
		gyro_offset            = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, field extremes
		push_sample(32'sd0, 32'sd0);
		push_sample(FULL_POS, FULL_POS);
		push_sample(FULL_NEG, FULL_NEG);
		push_sample(FULL_POS, FULL_NEG);
		push_sample(FULL_NEG, FULL_POS);
		push_sample(-32'sd1, 32'sd1);
		push_sample(32'sd1, -32'sd1);
		push_sample(32'sh5555_5555, 32'shAAAA_AAAA);
		push_sample(32'shAAAA_AAAA, 32'sh5555_5555);

		// largest period and noises, measurement noise of one; junk above dt, qa and qb
		settle();
		program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
		push_sample(FULL_POS, FULL_NEG);
		push_sample(FULL_NEG, FULL_POS);
		push_sample(32'sd0, FULL_POS);
		push_sample(FULL_POS, 32'sd0);

		// smallest period, no process noise, largest measurement noise
		settle();
		program_filter(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
		push_sample(32'sd12345678, -32'sd7654321);
		push_sample(FULL_NEG, FULL_POS);
		push_sample(32'sd0, 32'sd0);

		// zero period and zero measurement noise: drive the innovation variance to zero
		settle();
		program_filter(32'hFF00_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		push_sample(32'sd655360, 32'sd65536);
		push_sample(-32'sd655360, 32'sd131072);
		push_sample(32'sd3276800, -32'sd65536);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			program_filter(pick_period(), pick_noise(QA_RST), pick_noise(QB_RST),
				pick_noise(R_RST), phase[0]);
			gaps_on     <= (phase != QUIET_PHASE);
			gyro_offset = spread(5 * DEG);
			for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					push_sample($urandom, $urandom);
				end else begin
					heading = heading + spread(3 * DEG);
					if (heading > 180 * DEG)
						heading = 180 * DEG;
					if (heading < -180 * DEG)
						heading = -180 * DEG;
					push_sample(heading + spread(2 * DEG), spread(200 * DEG) + gyro_offset);
				end
			end
		end

		settle();
		repeat (SAMPLE_LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("kalman_angle_bias_filter_unit test passed");
		else
			$display("kalman_angle_bias_filter_unit test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("kalman_angle_bias_filter_unit test failed");
		$finish;
	end

endmodule
